[rtl/mrwg_pkg.sv]
package mrwg_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned VALUE_W = 15;
  localparam int unsigned GLYPH_W = 10;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned REM1_W  = 12;
  localparam int unsigned REM2_W  = 8;

  localparam int unsigned RADIX_R = 2250;
  localparam int unsigned RADIX_C = 150;
  localparam int unsigned RADIX_N = 10;
  localparam int unsigned MAX_DIGIT = 14;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } word_beat_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph0;
    logic [GLYPH_W-1:0] glyph1;
    logic [GLYPH_W-1:0] glyph2;
    logic [GLYPH_W-1:0] glyph3;
    logic               last_out;
  } glyph_beat_t;

  typedef struct packed {
    logic               sign;
    logic               last;
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W-1:0] c;
    logic [DIGIT_W-1:0] n;
    logic [DIGIT_W-1:0] b;
  } digits_t;

  // Quotient of x by a constant divisor d, for quotients up to fourteen.
  // All compares are independent and reduce to constant comparisons.
  function automatic logic [DIGIT_W-1:0] small_quot(input logic [VALUE_W-1:0] x,
                                                    input logic [REM1_W-1:0]  d);
    logic [DIGIT_W-1:0] q;
    q = '0;
    for (int unsigned k = 1; k <= MAX_DIGIT; k++) begin
      if (x >= VALUE_W'(VALUE_W'(d) * VALUE_W'(k))) begin
        q = DIGIT_W'(k);
      end
    end
    return q;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_r(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    case (d)
      4'd0:    g = 10'h072;
      4'd1:    g = 10'h052;
      4'd2:    g = 10'h154;
      4'd3:    g = 10'h155;
      4'd4:    g = 10'h156;
      4'd5:    g = 10'h157;
      4'd6:    g = 10'h158;
      4'd7:    g = 10'h159;
      4'd8:    g = 10'h1A6;
      4'd9:    g = 10'h210;
      4'd10:   g = 10'h211;
      4'd11:   g = 10'h212;
      4'd12:   g = 10'h213;
      4'd13:   g = 10'h24C;
      default: g = 10'h24D;
    endcase
    return g;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_c(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    case (d)
      4'd0:    g = 10'h063;
      4'd1:    g = 10'h043;
      4'd2:    g = 10'h106;
      4'd3:    g = 10'h107;
      4'd4:    g = 10'h108;
      4'd5:    g = 10'h109;
      4'd6:    g = 10'h10A;
      4'd7:    g = 10'h10B;
      4'd8:    g = 10'h10C;
      4'd9:    g = 10'h10D;
      4'd10:   g = 10'h187;
      4'd11:   g = 10'h188;
      4'd12:   g = 10'h0C7;
      4'd13:   g = 10'h23B;
      default: g = 10'h23C;
    endcase
    return g;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_n(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    case (d)
      4'd0:    g = 10'h06E;
      4'd1:    g = 10'h04E;
      4'd2:    g = 10'h143;
      4'd3:    g = 10'h144;
      4'd4:    g = 10'h145;
      4'd5:    g = 10'h146;
      4'd6:    g = 10'h147;
      4'd7:    g = 10'h148;
      4'd8:    g = 10'h19D;
      4'd9:    g = 10'h19E;
      4'd10:   g = 10'h0D1;
      4'd11:   g = 10'h1F8;
      4'd12:   g = 10'h1F9;
      4'd13:   g = 10'h220;
      default: g = 10'h235;
    endcase
    return g;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_b(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    case (d)
      4'd0:    g = 10'h062;
      4'd1:    g = 10'h042;
      4'd2:    g = 10'h180;
      4'd3:    g = 10'h181;
      4'd4:    g = 10'h183;
      4'd5:    g = 10'h184;
      4'd6:    g = 10'h185;
      4'd7:    g = 10'h0DF;
      4'd8:    g = 10'h0DE;
      default: g = 10'h0FE;
    endcase
    return g;
  endfunction

endpackage

[rtl/mixed_radix_word_to_glyphs.sv]
// Channel   Handshake                  Beat
// item      item_valid / item_ready    word_beat_t: word, last
// glyphs    glyph_valid / glyph_ready  glyph_beat_t: glyph0..glyph3, last_out
//
// Four register stages: three digit stages and one glyph register.
// A word passes the three digit stages and then the glyph register, and a new word
// is accepted every cycle while the output side keeps taking beats.
// Reset clears only the stage valid bits; data registers hold whatever they had.
// A stall at the output fills the empty stages first, then holds item_ready low.
module mixed_radix_word_to_glyphs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  mrwg_pkg::word_beat_t  item,
  output logic                  glyph_valid,
  input  logic                  glyph_ready,
  output mrwg_pkg::glyph_beat_t glyphs
);
  import mrwg_pkg::*;

  logic    digits_valid;
  logic    digits_ready;
  digits_t digits;

  mrwg_split u_split (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .digits_valid (digits_valid),
    .digits_ready (digits_ready),
    .digits       (digits)
  );

  mrwg_glyph u_glyph (
    .clk          (clk),
    .rst          (rst),
    .digits_valid (digits_valid),
    .digits_ready (digits_ready),
    .digits       (digits),
    .glyph_valid  (glyph_valid),
    .glyph_ready  (glyph_ready),
    .glyphs       (glyphs)
  );

endmodule

[rtl/mrwg_split.sv]
module mrwg_split (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mrwg_pkg::word_beat_t item,
  output logic                digits_valid,
  input  logic                digits_ready,
  output mrwg_pkg::digits_t   digits
);
  import mrwg_pkg::*;

  logic                v1;
  logic                v2;
  logic                v3;
  logic                adv1;
  logic                adv2;
  logic                adv3;

  logic                s1_sign;
  logic                s1_last;
  logic [DIGIT_W-1:0]  s1_r;
  logic [REM1_W-1:0]   s1_rem;

  logic                s2_sign;
  logic                s2_last;
  logic [DIGIT_W-1:0]  s2_r;
  logic [DIGIT_W-1:0]  s2_c;
  logic [REM2_W-1:0]   s2_rem;

  digits_t             s3;

  logic [VALUE_W-1:0]  value;
  logic [DIGIT_W-1:0]  r_next;
  logic [REM1_W-1:0]   rem1_next;
  logic [DIGIT_W-1:0]  c_next;
  logic [REM2_W-1:0]   rem2_next;
  logic [DIGIT_W-1:0]  n_next;
  logic [DIGIT_W-1:0]  b_next;

  assign adv3       = !v3 || digits_ready;
  assign adv2       = !v2 || adv3;
  assign adv1       = !v1 || adv2;
  assign item_ready = adv1;

  assign value     = item.word[VALUE_W-1:0];
  assign r_next    = small_quot(value, REM1_W'(RADIX_R));
  assign rem1_next = REM1_W'(value - VALUE_W'(VALUE_W'(r_next) * VALUE_W'(RADIX_R)));

  assign c_next    = small_quot(VALUE_W'(s1_rem), REM1_W'(RADIX_C));
  assign rem2_next = REM2_W'(s1_rem - REM1_W'(REM1_W'(c_next) * REM1_W'(RADIX_C)));

  assign n_next    = small_quot(VALUE_W'(s2_rem), REM1_W'(RADIX_N));
  assign b_next    = DIGIT_W'(s2_rem - REM2_W'(REM2_W'(n_next) * REM2_W'(RADIX_N)));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= item_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && item_valid) begin
      s1_sign <= item.word[WORD_W-1];
      s1_last <= item.last;
      s1_r    <= r_next;
      s1_rem  <= rem1_next;
    end
    if (adv2 && v1) begin
      s2_sign <= s1_sign;
      s2_last <= s1_last;
      s2_r    <= s1_r;
      s2_c    <= c_next;
      s2_rem  <= rem2_next;
    end
    if (adv3 && v2) begin
      s3.sign <= s2_sign;
      s3.last <= s2_last;
      s3.r    <= s2_r;
      s3.c    <= s2_c;
      s3.n    <= n_next;
      s3.b    <= b_next;
    end
  end

  assign digits_valid = v3;
  assign digits       = s3;

  a_rem1_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (s1_rem < REM1_W'(RADIX_R) && s1_r <= DIGIT_W'(MAX_DIGIT)))
    else $error("First remainder out of range.");

  a_rem2_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (s2_rem < REM2_W'(RADIX_C) && s2_c <= DIGIT_W'(MAX_DIGIT)))
    else $error("Second remainder out of range.");

  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (s3.b < DIGIT_W'(RADIX_N) && s3.n <= DIGIT_W'(MAX_DIGIT)))
    else $error("Low digits out of range.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !digits_ready) |=> (v3 && $stable(s3)))
    else $error("Stalled digit beat changed.");

endmodule

[rtl/mrwg_glyph.sv]
module mrwg_glyph (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 digits_valid,
  output logic                 digits_ready,
  input  mrwg_pkg::digits_t    digits,
  output logic                 glyph_valid,
  input  logic                 glyph_ready,
  output mrwg_pkg::glyph_beat_t glyphs
);
  import mrwg_pkg::*;

  logic               out_valid;
  logic               adv;
  glyph_beat_t        out_beat;
  glyph_beat_t        beat_next;
  logic [GLYPH_W-1:0] gr;
  logic [GLYPH_W-1:0] gc;
  logic [GLYPH_W-1:0] gn;
  logic [GLYPH_W-1:0] gb;

  assign adv          = !out_valid || glyph_ready;
  assign digits_ready = adv;

  assign gr = glyph_r(digits.r);
  assign gc = glyph_c(digits.c);
  assign gn = glyph_n(digits.n);
  assign gb = glyph_b(digits.b);

  always_comb begin
    beat_next.last_out = digits.last;
    if (digits.sign) begin
      beat_next.glyph0 = gn;
      beat_next.glyph1 = gb;
      beat_next.glyph2 = gr;
      beat_next.glyph3 = gc;
    end else begin
      beat_next.glyph0 = gr;
      beat_next.glyph1 = gc;
      beat_next.glyph2 = gn;
      beat_next.glyph3 = gb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= digits_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && digits_valid) begin
      out_beat <= beat_next;
    end
  end

  assign glyph_valid = out_valid;
  assign glyphs      = out_beat;

endmodule
